[rtl/mlr_pkg.sv]
`default_nettype none

package mlr_pkg;

    // Request kinds carried in the slave-side tuser bit.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

`default_nettype wire

[rtl/midpoint_line_rasterizer_unit.sv]
// Midpoint line rasterizer for lines from 0 to 90 degrees.
// Slave side: each word is a request. tuser selects the kind: a start word
// loads two endpoints from tdata (start_x, start_y, end_x, end_y from the
// lowest bit up) and gives no result; a step word gives the next pixel.
// Master side: each word is one pixel, tdata holding pixel_x then pixel_y,
// and tlast marks the final pixel of the line. A step word while no line is
// being drawn gives no word, and a start word abandons any line in progress.
// A step word accepted on the slave side is held in the input register until
// the output register can take its pixel, and the pixel is then offered from
// the output register.
// Throughput is one word per cycle on both sides while the receiver takes
// pixels; the walk (two compares, a decision add and coordinate increments
// per pixel) is done between the input register and the output register.
// When the receiver stalls, the pixel holds in the output register and the
// next step word waits in the input register; tready on the slave side
// drops only while both are full.
// Reset (synchronous, active low) empties both registers and leaves the
// block idle, so step words give nothing until the next start word.
`default_nettype none

module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = 9
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // req_type
    input  wire logic                                  i_s_tuser,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]          o_m_tdata,
    output logic                                       o_m_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam int DW    = COORD_BITS + 1;
    localparam int INC_W = COORD_BITS + 3;
    localparam int DEC_W = 2*COORD_BITS + 4;

    logic          r_in_vld;
    logic          r_in_req;
    logic [CB-1:0] r_in_sx;
    logic [CB-1:0] r_in_sy;
    logic [CB-1:0] r_in_ex;
    logic [CB-1:0] r_in_ey;

    logic [CB-1:0]           r_major;
    logic [CB-1:0]           r_minor;
    logic [CB-1:0]           r_major_end;
    logic signed [DEC_W-1:0] r_decision;
    logic signed [INC_W-1:0] r_inc_east;
    logic signed [INC_W-1:0] r_inc_ne;
    logic                    r_mirrored;
    logic                    r_drawing;

    logic          r_out_vld;
    logic [CB-1:0] r_px_x;
    logic [CB-1:0] r_px_y;
    logic          r_px_last;

    logic                    s_acc;
    logic                    s_is_step;
    logic                    s_emit;
    logic                    s_out_free;
    logic                    s_fire;

    logic                    s_swap;
    logic [CB-1:0]           s_ax;
    logic [CB-1:0]           s_ay;
    logic [CB-1:0]           s_bx;
    logic [CB-1:0]           s_by;
    logic signed [DW-1:0]    s_dx;
    logic signed [DW-1:0]    s_dy;
    logic                    s_mir;
    logic signed [DW-1:0]    s_dx_f;
    logic signed [DW-1:0]    s_dy_f;
    logic signed [DW-1:0]    s_dx_half;
    logic signed [DW:0]      s_half_diff;
    logic signed [DW:0]      s_diff;
    logic signed [INC_W-1:0] s_dec0;

    logic                    s_last;
    logic                    s_go_ne;
    logic signed [INC_W-1:0] s_inc;
    logic signed [DEC_W-1:0] n_decision;
    logic [CB-1:0]           n_major;
    logic [CB-1:0]           n_minor;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s_is_step  = (r_in_req == mlr_pkg::REQ_STEP);
    assign s_emit     = r_in_vld && s_is_step && r_drawing;
    assign s_out_free = !r_out_vld || i_m_tready;
    assign s_fire     = r_in_vld && (!s_emit || s_out_free);
    assign o_s_tready = !r_in_vld || s_fire;

    // Line setup: order the endpoints along x, then mirror steep lines.
    always_comb begin
        s_swap      = (r_in_sx >= r_in_ex);
        s_ax        = s_swap ? r_in_ex : r_in_sx;
        s_ay        = s_swap ? r_in_ey : r_in_sy;
        s_bx        = s_swap ? r_in_sx : r_in_ex;
        s_by        = s_swap ? r_in_sy : r_in_ey;
        s_dx        = $signed({1'b0, s_bx}) - $signed({1'b0, s_ax});
        s_dy        = $signed({1'b0, s_by}) - $signed({1'b0, s_ay});
        s_mir       = (s_dy > s_dx);
        s_dx_f      = s_mir ? s_dy : s_dx;
        s_dy_f      = s_mir ? s_dx : s_dy;
        s_dx_half   = s_dx_f >>> 1;
        s_half_diff = $signed({s_dy_f[DW-1], s_dy_f})
                    - $signed({s_dx_half[DW-1], s_dx_half});
        s_diff      = $signed({s_dy_f[DW-1], s_dy_f})
                    - $signed({s_dx_f[DW-1], s_dx_f});
        s_dec0      = $signed({s_half_diff, 1'b0});
    end

    // One step of the walk.
    always_comb begin
        s_last     = (r_major >= r_major_end);
        s_go_ne    = (r_decision > 0);
        s_inc      = s_go_ne ? r_inc_ne : r_inc_east;
        n_decision = r_decision + {{(DEC_W-INC_W){s_inc[INC_W-1]}}, s_inc};
        n_major    = r_major + CB'(1);
        n_minor    = s_go_ne ? r_minor + CB'(1) : r_minor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_req <= i_s_tuser;
            r_in_sx  <= i_s_tdata[CB-1:0];
            r_in_sy  <= i_s_tdata[2*CB-1:CB];
            r_in_ex  <= i_s_tdata[3*CB-1:2*CB];
            r_in_ey  <= i_s_tdata[4*CB-1:3*CB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major     <= '0;
            r_minor     <= '0;
            r_major_end <= '0;
            r_decision  <= '0;
            r_inc_east  <= '0;
            r_inc_ne    <= '0;
            r_mirrored  <= 1'b0;
            r_drawing   <= 1'b0;
        end else if (s_fire) begin
            if (!s_is_step) begin
                r_major     <= s_mir ? s_ay : s_ax;
                r_minor     <= s_mir ? s_ax : s_ay;
                r_major_end <= s_mir ? s_by : s_bx;
                r_decision  <= {{(DEC_W-INC_W){s_dec0[INC_W-1]}}, s_dec0};
                r_inc_east  <= $signed({s_dy_f[DW-1], s_dy_f, 1'b0});
                r_inc_ne    <= $signed({s_diff, 1'b0});
                r_mirrored  <= s_mir;
                r_drawing   <= 1'b1;
            end else if (r_drawing) begin
                r_major    <= n_major;
                r_minor    <= n_minor;
                r_decision <= n_decision;
                r_drawing  <= !s_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_out_free) begin
            r_out_vld <= s_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_free && s_emit) begin
            r_px_x    <= r_mirrored ? r_minor : r_major;
            r_px_y    <= r_mirrored ? r_major : r_minor;
            r_px_last <= s_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'({r_px_y, r_px_x});
    assign o_m_tlast  = r_px_last;

endmodule

`default_nettype wire

[rtl/mlr_checker.sv]
`default_nettype none

module mlr_checker #(
    parameter int COORD_BITS = 9
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_tvalid,
    input wire logic                              o_s_tready,
    input wire logic [((4*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    input wire logic                              i_s_tuser,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    input wire logic                              o_m_tlast
);

    // After reset no pixel word may be offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("pixel word offered straight after reset");

    // The slave side only stalls while a pixel word is itself stalled.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("request side stalled without a stalled pixel word");

    // A stalled pixel word keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled pixel word changed");

    // A start word never produces a pixel on its own: with the output side
    // empty and no word accepted just before it, accepting a start word leaves it empty.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == mlr_pkg::REQ_START)
            && !o_m_tvalid && $past(!i_s_tvalid || !o_s_tready)
            && $past(i_rst_n))
        |=> !o_m_tvalid)
        else $error("pixel word appeared without a step word");

endmodule

bind midpoint_line_rasterizer_unit mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (.*);

`default_nettype wire

[tb/sv/tb_midpoint_line_rasterizer_unit.sv]
`timescale 1ns / 100ps

module tb_midpoint_line_rasterizer_unit;

    localparam int CB         = 9;
    localparam int SW         = ((4*CB+7)/8)*8;
    localparam int MW         = ((2*CB+7)/8)*8;
    localparam int CMAX       = (1 << CB) - 1;
    localparam int LIMIT      = 400000;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;
    localparam int NROWS      = 25;
    localparam int RAND_WORDS = 1500;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } t_pixel;

    typedef struct packed {
        logic          kind;
        logic [CB-1:0] sx, sy, ex, ey;
        logic          typed;
        t_pixel        want;
    } t_row;

    localparam t_pixel NONE = '0;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          s_tuser = mlr_pkg::REQ_START;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic          m_tlast;

    int     walk_major, walk_minor, walk_end;
    longint midpoint_err, step_e, step_ne;
    bit     axes_swapped, line_active;
    t_pixel pixels_due[$];
    int     errors = 0;
    int     cycles = 0;
    int     words_sent = 0;
    int     burst_left = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    int     rx_phase = 0;
    t_row   plan [NROWS];

    midpoint_line_rasterizer_unit #(.COORD_BITS(CB)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic t_pixel pix(input int x, input int y, input bit l);
        pix.x    = x[CB-1:0];
        pix.y    = y[CB-1:0];
        pix.last = l;
    endfunction

    function automatic bit rasterise_word(input logic kind, input logic [SW-1:0] payload,
                                          output t_pixel px);
        int ax, ay, bx, by, t, dx, dy;
        px = NONE;
        if (kind == mlr_pkg::REQ_START) begin
            ax = int'(payload[CB-1:0]);
            ay = int'(payload[2*CB-1:CB]);
            bx = int'(payload[3*CB-1:2*CB]);
            by = int'(payload[4*CB-1:3*CB]);
            if (ax >= bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            axes_swapped = dy > dx;
            if (axes_swapped) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
                dx = bx - ax;
                dy = by - ay;
            end
            midpoint_err = 2 * (dy - dx / 2);
            step_e       = 2 * dy;
            step_ne      = 2 * (dy - dx);
            walk_major   = ax;
            walk_minor   = ay;
            walk_end     = bx;
            line_active  = 1'b1;
            return 1'b0;
        end
        if (!line_active)
            return 1'b0;
        px.x    = axes_swapped ? walk_minor[CB-1:0] : walk_major[CB-1:0];
        px.y    = axes_swapped ? walk_major[CB-1:0] : walk_minor[CB-1:0];
        px.last = walk_major >= walk_end;
        walk_major++;
        if (midpoint_err <= 0) begin
            midpoint_err += step_e;
        end else begin
            walk_minor++;
            midpoint_err += step_ne;
        end
        if (px.last)
            line_active = 1'b0;
        return 1'b1;
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_word(input logic kind, input logic [SW-1:0] payload,
                             input bit typed, input t_pixel want, output bit emitted);
        t_pixel px;
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = payload;
        do @(posedge clk); while (!s_tready);
        emitted = rasterise_word(kind, payload, px);
        if (emitted)
            pixels_due.push_back(typed ? want : px);
        words_sent++;
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pixels_due.size() != 0) @(negedge clk);
    endtask

    task automatic random_line(inout int counted);
        logic [CB-1:0] c [4];
        logic [SW-1:0] junk;
        int            pick, d, steps;
        bit            emitted;
        pick = $urandom_range(0, 39);
        for (int i = 0; i < 4; i++)
            c[i] = CB'($urandom_range(0, CMAX));
        if (pick == 1) begin
            for (int i = 0; i < 4; i++)
                c[i] = ($urandom_range(0, 1) != 0) ? CB'(CMAX) : '0;
        end else if (pick != 0) begin
            for (int i = 0; i < 2; i++) begin
                d = $urandom_range(0, 32);
                d = int'(c[i]) + d - 16;
                if (pick <= 3 && i == 0)
                    d = int'(c[0]);
                c[i+2] = (d < 0) ? '0 : (d > CMAX) ? CB'(CMAX) : CB'(d);
            end
        end
        send_word(mlr_pkg::REQ_START, SW'({c[3], c[2], c[1], c[0]}), 1'b0, NONE, emitted);
        counted++;
        steps = walk_end - walk_major + 1;
        if ($urandom_range(0, 9) == 0)
            steps = $urandom_range(0, steps - 1);
        else if ($urandom_range(0, 3) == 0)
            steps += $urandom_range(1, 2);
        repeat (steps) begin
            junk = SW'({$urandom, $urandom});
            junk[SW-1:4*CB] = '0;
            send_word(mlr_pkg::REQ_STEP, junk, 1'b0, NONE, emitted);
            if (emitted)
                counted++;
        end
    endtask

    // The receiver's own pattern, with one long hold-off once enough words have gone in.
    always @(negedge clk) begin
        rx_phase <= rx_phase + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (rx_phase[6:5] == 2'b01) begin
            m_tready <= 1'b1;
        end else if (rx_phase[6:5] == 2'b11) begin
            m_tready <= ($urandom_range(0, 3) == 0);
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk) begin
        t_pixel seen, due;
        if (rst_n && m_tvalid && m_tready) begin
            seen = {m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast};
            if (pixels_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                         $time, seen.x, seen.y, seen.last);
            end else begin
                due = pixels_due.pop_front();
                if (seen.x !== due.x) begin
                    errors++;
                    $display("%0t: pixel_x expected %0d got %0d", $time, due.x, seen.x);
                end
                if (seen.y !== due.y) begin
                    errors++;
                    $display("%0t: pixel_y expected %0d got %0d", $time, due.y, seen.y);
                end
                if (seen.last !== due.last) begin
                    errors++;
                    $display("%0t: last_pixel expected %0b got %0b",
                             $time, due.last, seen.last);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row r;
        bit   emitted;
        int   counted, lines;
        plan = '{
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_START,   0,   0,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(0, 0, 1)},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_START, 511, 511, 511, 511, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(511, 511, 1)},
            '{mlr_pkg::REQ_START, 509,   0, 511,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(509, 0, 0)},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(510, 0, 0)},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(511, 0, 1)},
            '{mlr_pkg::REQ_START,   5, 511,   5, 509, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(5, 509, 0)},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(5, 510, 0)},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(5, 511, 1)},
            '{mlr_pkg::REQ_START,   0, 511,   2,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(0, 511, 0)},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(1, 511, 0)},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b1, pix(2, 511, 1)},
            '{mlr_pkg::REQ_START,  10,  10,  20,  15, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_START,   2,   2,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b0, NONE},
            '{mlr_pkg::REQ_STEP,    0,   0,   0,   0, 1'b0, NONE}
        };
        walk_major   = 0;
        walk_minor   = 0;
        walk_end     = 0;
        midpoint_err = 0;
        step_e       = 0;
        step_ne      = 0;
        axes_swapped = 1'b0;
        line_active  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i]) begin
            r = plan[i];
            send_word(r.kind, SW'({r.ey, r.ex, r.sy, r.sx}), r.typed, r.want, emitted);
        end
        drain();

        counted = 0;
        lines   = 0;
        while (counted < RAND_WORDS) begin
            random_line(counted);
            lines++;
            if (lines == 40)
                drain();
        end
        s_tvalid = 1'b0;

        while (pixels_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
